>>> src/agl_pkg.sv
// Shared constants and types for the gain, gate and limiter block.
`timescale 1ns / 1ps

package agl_pkg;

    localparam int GAIN_W    = 16;
    localparam int FRAC_BITS = 12;
    localparam int LVL_W     = 15;
    localparam int CH_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CH_W-1:0] CH_STEREO = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN      = 3'd0,
        CFG_GATE_EN   = 3'd1,
        CFG_GATE_LVL  = 3'd2,
        CFG_LIMIT_EN  = 3'd3,
        CFG_LIMIT_LVL = 3'd4,
        CFG_CHANNELS  = 3'd5
    } t_cfg_idx;

endpackage

>>> src/agl_gain.sv
// Q4.12 gain stage: multiply, round half up, saturate to the sample range.
`timescale 1ns / 1ps

module agl_gain #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic signed [SAMPLE_BITS-1:0]    i_sample,
    input  logic [agl_pkg::GAIN_W-1:0]       i_gain,
    output logic [SAMPLE_BITS-1:0]           o_sample
);

    localparam int PW = SAMPLE_BITS + agl_pkg::GAIN_W + 1;
    localparam logic signed [PW-1:0] RND  = PW'(1) <<< (agl_pkg::FRAC_BITS - 1);
    localparam logic signed [PW-1:0] SMAX = PW'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [PW-1:0] SMIN = ~SMAX;

    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_sum;
    logic signed [PW-1:0] w_shift;

    assign w_prod  = i_sample * $signed({1'b0, i_gain});
    assign w_sum   = w_prod + RND;
    assign w_shift = w_sum >>> agl_pkg::FRAC_BITS;

    always_comb begin
        if (w_shift > SMAX) begin
            o_sample = SMAX[SAMPLE_BITS-1:0];
        end else if (w_shift < SMIN) begin
            o_sample = SMIN[SAMPLE_BITS-1:0];
        end else begin
            o_sample = w_shift[SAMPLE_BITS-1:0];
        end
    end

endmodule

>>> src/audio_gain_gate_limiter_top.sv
// Top level: stereo gain, noise gate, hard limiter and running peak meters.
`timescale 1ns / 1ps

// Takes one frame per clock and returns one result beat per frame, presented
// from the result register once the beat has left the input register. The
// two registers are the input register, and the result register that holds
// the scaled, gated and limited samples with the running peaks, all formed
// in one pass of logic between them. Sustained rate is one frame per cycle.
// The input holds off only while the result register is full and not taken.
// Peaks restart on the frame after one with tlast set. Write configuration
// only while the block is empty.
module audio_gain_gate_limiter_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [agl_pkg::CFG_IDX_W-1:0]             i_cfg_idx,
    input  logic [agl_pkg::CFG_DAT_W-1:0]             i_cfg_data,
    input  logic                                      i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // left_in, right_in
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        i_s_axis_tdata,
    // block_end
    input  logic                                      i_s_axis_tlast,
    output logic                                      o_m_axis_tvalid,
    input  logic                                      i_m_axis_tready,
    // left_out, right_out, peak_left_out, peak_right_out
    output logic [((4*SAMPLE_BITS+7)/8)*8-1:0]        o_m_axis_tdata,
    // block_last
    output logic                                      o_m_axis_tlast
);

    localparam int SB    = SAMPLE_BITS;
    localparam int OUT_W = ((4*SAMPLE_BITS+7)/8)*8;
    localparam int CW    = ((SB + 1 > agl_pkg::LVL_W + 1) ? SB + 1 : agl_pkg::LVL_W + 1) + 1;
    localparam int LW    = ((SB > agl_pkg::LVL_W) ? SB : agl_pkg::LVL_W) + 1;

    logic [agl_pkg::GAIN_W-1:0]  r_gain;
    logic                        r_gate_en;
    logic [agl_pkg::LVL_W-1:0]   r_gate_lvl;
    logic                        r_lim_en;
    logic [agl_pkg::LVL_W-1:0]   r_lim_lvl;
    logic [agl_pkg::CH_W-1:0]    r_ch;

    logic                        w_adv;
    logic                        r_in_vld, r_out_vld;
    logic [SB-1:0]               r_in_l, r_in_r;
    logic                        r_in_last, r_out_last;
    logic [SB-1:0]               w_g_l, w_g_r;
    logic [SB-1:0]               r_pk_l, r_pk_r;
    logic [SB-1:0]               r_o_l, r_o_r, r_o_pl, r_o_pr;

    logic                        w_stereo;
    logic [SB-1:0]               w_s_r;
    logic [SB-1:0]               w_mag_l, w_mag_r;
    logic                        w_gated;
    logic [SB-1:0]               w_gl, w_gr, w_gmag_l, w_gmag_r;
    logic [SB-1:0]               w_lim, w_lim_neg;
    logic                        w_over_l, w_over_r;
    logic [SB-1:0]               w_fl, w_fr, w_fmag_l, w_fmag_r;
    logic [SB-1:0]               w_pk_l, w_pk_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= agl_pkg::GAIN_W'(4096);
            r_gate_en  <= 1'b0;
            r_gate_lvl <= agl_pkg::LVL_W'(328);
            r_lim_en   <= 1'b0;
            r_lim_lvl  <= agl_pkg::LVL_W'(29204);
            r_ch       <= agl_pkg::CH_STEREO;
        end else if (i_cfg_we) begin
            case (agl_pkg::t_cfg_idx'(i_cfg_idx))
                agl_pkg::CFG_GAIN:      r_gain     <= i_cfg_data;
                agl_pkg::CFG_GATE_EN:   r_gate_en  <= i_cfg_data[0];
                agl_pkg::CFG_GATE_LVL:  r_gate_lvl <= i_cfg_data[agl_pkg::LVL_W-1:0];
                agl_pkg::CFG_LIMIT_EN:  r_lim_en   <= i_cfg_data[0];
                agl_pkg::CFG_LIMIT_LVL: r_lim_lvl  <= i_cfg_data[agl_pkg::LVL_W-1:0];
                agl_pkg::CFG_CHANNELS:  r_ch       <= i_cfg_data[agl_pkg::CH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_adv           = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // advance all stages together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_in_vld  <= i_s_axis_tvalid;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_l     <= i_s_axis_tdata[SB-1:0];
            r_in_r     <= i_s_axis_tdata[2*SB-1:SB];
            r_in_last  <= i_s_axis_tlast;
            r_o_l      <= w_fl;
            r_o_r      <= w_fr;
            r_o_pl     <= w_pk_l;
            r_o_pr     <= w_pk_r;
            r_out_last <= r_in_last;
        end
    end

    agl_gain #(.SAMPLE_BITS(SB)) u_gain_l (
        .i_sample (r_in_l),
        .i_gain   (r_gain),
        .o_sample (w_g_l)
    );

    agl_gain #(.SAMPLE_BITS(SB)) u_gain_r (
        .i_sample (r_in_r),
        .i_gain   (r_gain),
        .o_sample (w_g_r)
    );

    assign w_stereo = (r_ch == agl_pkg::CH_STEREO);
    assign w_s_r    = w_stereo ? w_g_r : '0;
    assign w_mag_l  = w_g_l[SB-1] ? (~w_g_l + 1'b1) : w_g_l;
    assign w_mag_r  = w_s_r[SB-1] ? (~w_s_r + 1'b1) : w_s_r;

    always_comb begin
        if (w_stereo) begin
            w_gated = r_gate_en &&
                      ((CW'(w_mag_l) + CW'(w_mag_r)) < CW'({r_gate_lvl, 1'b0}));
        end else begin
            w_gated = r_gate_en && (CW'(w_mag_l) < CW'(r_gate_lvl));
        end
    end

    assign w_gl     = w_gated ? '0 : w_g_l;
    assign w_gr     = w_gated ? '0 : w_s_r;
    assign w_gmag_l = w_gated ? '0 : w_mag_l;
    assign w_gmag_r = w_gated ? '0 : w_mag_r;

    assign w_lim     = SB'(r_lim_lvl);
    assign w_lim_neg = ~w_lim + 1'b1;
    assign w_over_l  = r_lim_en && (LW'(w_gmag_l) > LW'(r_lim_lvl));
    assign w_over_r  = r_lim_en && (LW'(w_gmag_r) > LW'(r_lim_lvl));

    assign w_fl      = w_over_l ? (w_gl[SB-1] ? w_lim_neg : w_lim) : w_gl;
    assign w_fr      = w_over_r ? (w_gr[SB-1] ? w_lim_neg : w_lim) : w_gr;
    assign w_fmag_l  = w_over_l ? w_lim : w_gmag_l;
    assign w_fmag_r  = w_over_r ? w_lim : w_gmag_r;

    assign w_pk_l = (w_fmag_l > r_pk_l) ? w_fmag_l : r_pk_l;
    always_comb begin
        if (w_stereo) begin
            w_pk_r = (w_fmag_r > r_pk_r) ? w_fmag_r : r_pk_r;
        end else begin
            w_pk_r = w_pk_l;
        end
    end

    // restart peaks after the last frame of a block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pk_l <= '0;
            r_pk_r <= '0;
        end else if (w_adv && r_in_vld) begin
            r_pk_l <= r_in_last ? '0 : w_pk_l;
            r_pk_r <= r_in_last ? '0 : w_pk_r;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = OUT_W'({r_o_pr, r_o_pl, r_o_r, r_o_l});

endmodule

>>> src/agl_checker.sv
// Port-level checks for the gain, gate and limiter block, with its bind.
`timescale 1ns / 1ps

module agl_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      o_s_axis_tready,
    input  logic                                      o_m_axis_tvalid,
    input  logic                                      i_m_axis_tready,
    input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]        o_m_axis_tdata,
    input  logic                                      o_m_axis_tlast
);

    localparam int SB = SAMPLE_BITS;

    logic [SB-1:0] w_out_l, w_mag_l, w_pk_l;
    logic          w_out_acc;
    logic          r_seen, r_prev_last;
    logic [SB-1:0] r_prev_pk;

    assign w_out_l   = o_m_axis_tdata[SB-1:0];
    assign w_pk_l    = o_m_axis_tdata[3*SB-1:2*SB];
    assign w_mag_l   = w_out_l[SB-1] ? (~w_out_l + 1'b1) : w_out_l;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_prev_last <= 1'b0;
        end else if (w_out_acc) begin
            r_seen      <= 1'b1;
            r_prev_last <= o_m_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_acc) begin
            r_prev_pk <= w_pk_l;
        end
    end

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input held off with an empty result register");

    a_peak_covers_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_pk_l >= w_mag_l))
        else $error("left peak below left sample magnitude");

    a_peak_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && r_seen && !r_prev_last |-> (w_pk_l >= r_prev_pk))
        else $error("left peak fell inside a block");

endmodule

bind audio_gain_gate_limiter_top agl_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_agl_checker (.*);

>>> bench/testbench.sv
// Self-checking bench for the gain, noise gate and limiter block with peak meters.
`timescale 1ns / 1ps

module testbench;

    localparam int SB         = 16;
    localparam int IN_W       = ((2*SB+7)/8)*8;
    localparam int OUT_W      = ((4*SB+7)/8)*8;
    localparam int IDX_W      = agl_pkg::CFG_IDX_W;
    localparam int DAT_W      = agl_pkg::CFG_DAT_W;
    localparam int CYCLE_CAP  = 200000;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 64;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 128;
    localparam logic [IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
        logic [SB-1:0]        peak_l;
        logic [SB-1:0]        peak_r;
        logic                 last;
    } t_frame_result;

    typedef struct {
        bit                    is_cfg;
        logic [IDX_W-1:0]      idx;
        logic [DAT_W-1:0]      data;
        logic signed [SB-1:0]  l;
        logic signed [SB-1:0]  r;
        bit                    last;
        bit                    known;
        t_frame_result         want;
    } t_plan_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [IDX_W-1:0]     i_cfg_idx = '0;
    logic [DAT_W-1:0]     i_cfg_data = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [IN_W-1:0]      i_s_axis_tdata = '0;
    logic                 i_s_axis_tlast = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     o_m_axis_tdata;
    logic                 o_m_axis_tlast;

    // frame model: configuration and running peaks
    int gain_m, gate_en_m, gate_lvl_m, limit_en_m, limit_lvl_m, chan_m;
    int peak_l_run, peak_r_run;

    t_frame_result frames_due[$];
    t_plan_row     plan[$];
    int            mismatches = 0;
    int            results_seen = 0;
    bit            steady = 1'b0;

    audio_gain_gate_limiter_top #(.SAMPLE_BITS(SB)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    function automatic int mag(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int scale_sample(logic signed [SB-1:0] s);
        longint prod;
        longint scaled;
        prod = longint'(s) * longint'(gain_m);
        scaled = (prod + 2048) >>> agl_pkg::FRAC_BITS;
        if (scaled > 32767) scaled = 32767;
        if (scaled < -32768) scaled = -32768;
        return int'(scaled);
    endfunction

    function automatic int clamp_sample(int s);
        if (limit_en_m != 0 && mag(s) > limit_lvl_m) begin
            return (s > 0) ? limit_lvl_m : -limit_lvl_m;
        end
        return s;
    endfunction

    function automatic void cfg_model(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] data);
        case (idx)
            agl_pkg::CFG_GAIN:      gain_m      = int'(data);
            agl_pkg::CFG_GATE_EN:   gate_en_m   = int'(data[0]);
            agl_pkg::CFG_GATE_LVL:  gate_lvl_m  = int'(data[agl_pkg::LVL_W-1:0]);
            agl_pkg::CFG_LIMIT_EN:  limit_en_m  = int'(data[0]);
            agl_pkg::CFG_LIMIT_LVL: limit_lvl_m = int'(data[agl_pkg::LVL_W-1:0]);
            agl_pkg::CFG_CHANNELS:  chan_m      = int'(data[agl_pkg::CH_W-1:0]);
            default: ;
        endcase
    endfunction

    function automatic t_frame_result predict_frame(logic signed [SB-1:0] l_in,
                                                    logic signed [SB-1:0] r_in, bit last);
        t_frame_result res;
        bit stereo;
        bit gated;
        int l, r, pl, pr;
        stereo = (chan_m == int'(agl_pkg::CH_STEREO));
        l = scale_sample(l_in);
        r = stereo ? scale_sample(r_in) : 0;
        if (gate_en_m != 0) begin
            gated = stereo ? (mag(l) + mag(r) < 2 * gate_lvl_m) : (mag(l) < gate_lvl_m);
            if (gated) begin
                l = 0;
                r = 0;
            end
        end
        l = clamp_sample(l);
        r = clamp_sample(r);
        pl = (mag(l) > peak_l_run) ? mag(l) : peak_l_run;
        if (stereo) begin
            pr = (mag(r) > peak_r_run) ? mag(r) : peak_r_run;
        end else begin
            pr = pl;
        end
        res.left   = l[SB-1:0];
        res.right  = r[SB-1:0];
        res.peak_l = pl[SB-1:0];
        res.peak_r = pr[SB-1:0];
        res.last   = last;
        peak_l_run = last ? 0 : pl;
        peak_r_run = last ? 0 : pr;
        return res;
    endfunction

    function automatic void add_reg(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] data);
        t_plan_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        plan.push_back(row);
    endfunction

    function automatic void add_frame(int l, int r, bit last);
        t_plan_row row;
        row = '{default: '0};
        row.l = l[SB-1:0];
        row.r = r[SB-1:0];
        row.last = last;
        plan.push_back(row);
    endfunction

    function automatic void add_known(int l, int r, bit last,
                                      int lo, int ro, int pl, int pr);
        t_plan_row row;
        row = '{default: '0};
        row.l = l[SB-1:0];
        row.r = r[SB-1:0];
        row.last = last;
        row.known = 1'b1;
        row.want.left = lo[SB-1:0];
        row.want.right = ro[SB-1:0];
        row.want.peak_l = pl[SB-1:0];
        row.want.peak_r = pr[SB-1:0];
        row.want.last = last;
        plan.push_back(row);
    endfunction

    function automatic logic signed [SB-1:0] pick_sample();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = int'($urandom_range(65535)) - 32768;
            4, 5:       v = int'($urandom_range(1023)) - 512;
            6, 7: begin
                v = int'($urandom_range(2 * gate_lvl_m + 8));
                if ($urandom_range(1) == 1) v = -v;
            end
            8:          v = 32767 - int'($urandom_range(15));
            default:    v = -32768 + int'($urandom_range(15));
        endcase
        return v[SB-1:0];
    endfunction

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] data);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_model(idx, data);
    endtask

    task automatic send_frame(logic signed [SB-1:0] l, logic signed [SB-1:0] r, bit last,
                              bit known, t_frame_result want);
        t_frame_result modeled;
        bit idle;
        idle = 1'b1;
        while (idle) begin
            @(negedge i_clk);
            idle = !steady && ($urandom_range(99) < 21);
            if (idle) i_s_axis_tvalid <= 1'b0;
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r, l};
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        modeled = predict_frame(l, r, last);
        frames_due.push_back(known ? want : modeled);
    endtask

    task automatic report_mismatch(string what, t_frame_result want, t_frame_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: expected l=%0d r=%0d pkl=%0d pkr=%0d last=%0b,",
                     $realtime, what, want.left, want.right, want.peak_l, want.peak_r,
                     want.last);
            $display("    got l=%0d r=%0d pkl=%0d pkr=%0d last=%0b",
                     got.left, got.right, got.peak_l, got.peak_r, got.last);
        end
    endtask

    // result beat check
    initial begin
        t_frame_result got;
        t_frame_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                got.left   = o_m_axis_tdata[SB-1:0];
                got.right  = o_m_axis_tdata[2*SB-1:SB];
                got.peak_l = o_m_axis_tdata[3*SB-1:2*SB];
                got.peak_r = o_m_axis_tdata[4*SB-1:3*SB];
                got.last   = o_m_axis_tlast;
                results_seen++;
                if (frames_due.size() == 0) begin
                    report_mismatch("unexpected beat", '0, got);
                end else begin
                    want = frames_due.pop_front();
                    if (got.left !== want.left || got.right !== want.right ||
                        got.peak_l !== want.peak_l || got.peak_r !== want.peak_r ||
                        got.last !== want.last) begin
                        report_mismatch("mismatch", want, got);
                    end
                end
            end
        end
    end

    // output ready: random stalls, one long hold-off to back up the pipeline
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= steady || ($urandom_range(99) >= 21);
            end
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_CAP) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_plan_row row;
        t_frame_result none;
        logic [DAT_W-1:0] gain_w;
        int n;
        none = '0;
        gain_m = 4096;
        gate_en_m = 0;
        gate_lvl_m = 328;
        limit_en_m = 0;
        limit_lvl_m = 29204;
        chan_m = int'(agl_pkg::CH_STEREO);
        peak_l_run = 0;
        peak_r_run = 0;

        add_known(0, 0, 0, 0, 0, 0, 0);
        add_known(32767, -32768, 0, 32767, -32768, 32767, 32768);
        add_known(-1, 1, 1, -1, 1, 32767, 32768);
        add_known(5, -7, 0, 5, -7, 5, 7);
        add_reg(agl_pkg::CFG_GAIN, 16'd0);
        add_known(-32768, 32767, 1, 0, 0, 5, 7);
        add_reg(agl_pkg::CFG_GAIN, 16'hFFFF);
        add_known(32767, -32768, 0, 32767, -32768, 32767, 32768);
        add_frame(1, -1, 1);
        add_reg(agl_pkg::CFG_GAIN, 16'd2048);
        add_frame(3, -3, 0);
        add_frame(1, -1, 1);
        add_reg(agl_pkg::CFG_GAIN, 16'd4096);
        add_reg(agl_pkg::CFG_GATE_LVL, 16'd100);
        add_reg(agl_pkg::CFG_GATE_EN, 16'd1);
        add_known(60, -39, 0, 0, 0, 0, 0);
        add_known(100, -100, 0, 100, -100, 100, 100);
        add_frame(-32768, 0, 1);
        add_reg(agl_pkg::CFG_CHANNELS, 16'd1);
        add_known(99, 12345, 0, 0, 0, 0, 0);
        add_known(-100, -5, 0, -100, 0, 100, 100);
        add_reg(agl_pkg::CFG_LIMIT_LVL, 16'd1000);
        add_reg(agl_pkg::CFG_LIMIT_EN, 16'd1);
        add_frame(-32768, 7, 0);
        add_frame(1001, -3, 0);
        add_frame(1000, 0, 1);
        add_reg(agl_pkg::CFG_CHANNELS, 16'd0);
        add_frame(-2000, 500, 0);
        add_reg(agl_pkg::CFG_CHANNELS, 16'd3);
        add_frame(1500, 1500, 0);
        add_reg(agl_pkg::CFG_CHANNELS, 16'd2);
        add_frame(-300, 32767, 0);
        add_reg(agl_pkg::CFG_GATE_EN, 16'hFFFE);
        add_reg(CFG_SPARE_A, 16'hFFFF);
        add_reg(CFG_SPARE_B, 16'h0000);
        add_reg(agl_pkg::CFG_LIMIT_LVL, 16'hFFFF);
        add_frame(-32768, 12, 1);
        add_reg(agl_pkg::CFG_GATE_EN, 16'd1);
        add_reg(agl_pkg::CFG_GATE_LVL, 16'h7FFF);
        add_frame(32767, -32768, 0);
        add_frame(32767, 32766, 0);
        add_reg(agl_pkg::CFG_LIMIT_LVL, 16'd0);
        add_reg(agl_pkg::CFG_GATE_EN, 16'd0);
        add_frame(-32768, 32767, 1);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (plan.size() != 0) begin
            row = plan.pop_front();
            if (row.is_cfg) begin
                write_reg(row.idx, row.data);
            end else begin
                send_frame(row.l, row.r, row.last, row.known, row.want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            steady = (ph == 1);
            case ($urandom_range(4))
                0:       gain_w = 16'd4096;
                1:       gain_w = 16'($urandom_range(65535));
                2:       gain_w = 16'($urandom_range(8192, 2048));
                3:       gain_w = ($urandom_range(1) == 1) ? 16'hFFFF : 16'd0;
                default: gain_w = 16'($urandom_range(4096));
            endcase
            if (ph == 6) gain_w = 16'hFFFF;
            write_reg(agl_pkg::CFG_GAIN, gain_w);
            write_reg(agl_pkg::CFG_GATE_EN, 16'($urandom_range(1)));
            write_reg(agl_pkg::CFG_GATE_LVL,
                      ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                               : 16'($urandom_range(1500)));
            write_reg(agl_pkg::CFG_LIMIT_EN, 16'($urandom_range(1)));
            write_reg(agl_pkg::CFG_LIMIT_LVL,
                      ($urandom_range(1) == 0) ? 16'($urandom_range(32767, 20000))
                                               : 16'($urandom_range(65535)));
            write_reg(agl_pkg::CFG_CHANNELS,
                      ($urandom_range(3) != 0) ? 16'(agl_pkg::CH_STEREO)
                                               : 16'($urandom_range(3)));
            if ($urandom_range(3) == 0) write_reg(CFG_SPARE_B, 16'($urandom_range(65535)));
            for (n = 0; n < PHASE_LEN; n++) begin
                send_frame(pick_sample(), pick_sample(), $urandom_range(15) == 0, 1'b0, none);
            end
        end
        steady = 1'b0;

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
src/agl_pkg.sv
src/agl_gain.sv
src/audio_gain_gate_limiter_top.sv
src/agl_checker.sv
bench/testbench.sv
